// ===== rtl/onewire_master_slot_engine_macros.svh =====
// ----------------------------------------------------------------------------
// 1-Wire master assertion macros
// Shared clocked assertion forms for the slot engine checks.
// ----------------------------------------------------------------------------
`ifndef ONEWIRE_MASTER_SLOT_ENGINE_MACROS_SVH
`define ONEWIRE_MASTER_SLOT_ENGINE_MACROS_SVH

// same-cycle implication, held off during reset
`define OWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, held off during reset
`define OWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/owm_pkg.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master package
// Widths, register indexes, mode codes, shared types and the timer clamp.
// ----------------------------------------------------------------------------
package owm_pkg;

  localparam int TIMER_WIDTH = 10;
  localparam int CLAMP_W     = (TIMER_WIDTH > 10) ? TIMER_WIDTH : 10;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT          = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT_LOW     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE0_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [7:0] PRESENCE_WAIT_DEF = 8'd70;
  localparam logic [9:0] RESET_TAIL_DEF    = 10'd410;
  localparam logic [7:0] SLOT_DEF          = 8'd70;
  localparam logic [5:0] SHORT_LOW_DEF     = 6'd6;
  localparam logic [7:0] WRITE0_LOW_DEF    = 8'd60;
  localparam logic [5:0] READ_SAMPLE_DEF   = 6'd9;

  localparam logic [2:0] MODE_RESET    = 3'd0;
  localparam logic [2:0] MODE_WR_BIT   = 3'd1;
  localparam logic [2:0] MODE_RD_BIT   = 3'd2;
  localparam logic [2:0] MODE_WR_BYTE  = 3'd3;
  localparam logic [2:0] MODE_RD_BYTE  = 3'd4;

  typedef struct packed {
    logic [9:0] reset_low;
    logic [7:0] presence_wait;
    logic [9:0] reset_tail;
    logic [7:0] slot;
    logic [5:0] short_low;
    logic [7:0] write0_low;
    logic [5:0] read_sample;
  } cfg_t;

  typedef struct packed {
    logic       cmd_ok;
    logic       is_reset;
    logic [2:0] mode;
    logic [7:0] shift;
    logic       bus;
  } item_t;

  function automatic logic [TIMER_WIDTH-1:0] clamp_len(logic [9:0] len);
    logic [CLAMP_W-1:0] wide;
    logic [CLAMP_W-1:0] lim;
    wide = CLAMP_W'(len);
    lim  = CLAMP_W'({TIMER_WIDTH{1'b1}});
    if (wide > lim) begin
      return {TIMER_WIDTH{1'b1}};
    end
    return wide[TIMER_WIDTH-1:0];
  endfunction

endpackage

// ===== rtl/owm_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master configuration registers
// Timing registers written by index, reset to standard-speed values.
// ----------------------------------------------------------------------------
module owm_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output owm_pkg::cfg_t                  cfg_o
);
  import owm_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_RESET_LOW:     cfg_d.reset_low     = cfg_wdata_i[9:0];
        REG_PRESENCE_WAIT: cfg_d.presence_wait = cfg_wdata_i[7:0];
        REG_RESET_TAIL:    cfg_d.reset_tail    = cfg_wdata_i[9:0];
        REG_SLOT:          cfg_d.slot          = cfg_wdata_i[7:0];
        REG_SHORT_LOW:     cfg_d.short_low     = cfg_wdata_i[5:0];
        REG_WRITE0_LOW:    cfg_d.write0_low    = cfg_wdata_i[7:0];
        REG_READ_SAMPLE:   cfg_d.read_sample   = cfg_wdata_i[5:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low     <= RESET_LOW_DEF;
      cfg_q.presence_wait <= PRESENCE_WAIT_DEF;
      cfg_q.reset_tail    <= RESET_TAIL_DEF;
      cfg_q.slot          <= SLOT_DEF;
      cfg_q.short_low     <= SHORT_LOW_DEF;
      cfg_q.write0_low    <= WRITE0_LOW_DEF;
      cfg_q.read_sample   <= READ_SAMPLE_DEF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/owm_front.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master front end
// Accepts tick requests and classifies the command they carry.
// ----------------------------------------------------------------------------
module owm_front (
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic           cmd_valid_i,
  input  logic [2:0]     mode_i,
  input  logic [7:0]     tx_data_i,
  input  logic           bus_level_i,
  input  logic           q_full_i,
  output logic           q_push_o,
  output owm_pkg::item_t q_item_o
);
  import owm_pkg::*;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_item_o.cmd_ok   = cmd_valid_i && (mode_i <= MODE_RD_BYTE);
    q_item_o.is_reset = (mode_i == MODE_RESET);
    q_item_o.mode     = mode_i;
    q_item_o.bus      = bus_level_i;
    case (mode_i)
      MODE_WR_BIT:  q_item_o.shift = {7'd0, tx_data_i[0]};
      MODE_WR_BYTE: q_item_o.shift = tx_data_i;
      default:      q_item_o.shift = 8'd0;
    endcase
  end

endmodule

// ===== rtl/owm_queue.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master request queue
// Short FIFO between the front end and the slot sequencer.
// ----------------------------------------------------------------------------
module owm_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  owm_pkg::item_t item_i,
  input  logic           pop_i,
  output owm_pkg::item_t item_o,
  output logic           full_o,
  output logic           empty_o
);
  import owm_pkg::*;

  item_t mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/owm_back.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master slot sequencer
// Runs reset and slot phases one tick per request, registers the result.
// ----------------------------------------------------------------------------
module owm_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  owm_pkg::cfg_t  cfg_i,
  input  owm_pkg::item_t item_i,
  input  logic           q_empty_i,
  output logic           q_pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output logic           drive_low_o,
  output logic           busy_res_o,
  output logic           done_res_o,
  output logic [7:0]     rx_data_o,
  output logic           no_device_o
);
  import owm_pkg::*;

  typedef enum logic [6:0] {
    PH_IDLE  = 7'b0000001,
    PH_RLOW  = 7'b0000010,
    PH_RWAIT = 7'b0000100,
    PH_RSAMP = 7'b0001000,
    PH_RTAIL = 7'b0010000,
    PH_SLOW  = 7'b0100000,
    PH_SREL  = 7'b1000000
  } phase_e;

  localparam int TW = TIMER_WIDTH;

  function automatic logic [7:0] low_len(logic rd, logic b0, cfg_t c);
    return (rd || b0) ? {2'd0, c.short_low} : c.write0_low;
  endfunction

  function automatic logic [7:0] rel_len(logic rd, logic [7:0] lo, cfg_t c);
    logic [7:0] r;
    logic [7:0] rmin;
    r    = (c.slot > lo) ? c.slot - lo : 8'd0;
    rmin = {2'd0, c.read_sample} + 8'd1;
    if (rd) begin
      if (r < rmin) r = rmin;
    end else if (lo == 8'd0 && r == 8'd0) begin
      r = 8'd1;
    end
    return r;
  endfunction

  phase_e      phase_q, phase_d, cur_ph, eos_ph;
  logic [TW-1:0] tick_q, tick_d, cur_tick, len;
  logic [TW:0]   tick_inc;
  logic [3:0]  bit_q, bit_d, cur_bit, eos_bit, slots;
  logic [7:0]  shift_q, shift_d, cur_shift, smp_shift, eos_shift;
  logic [2:0]  mode_q, mode_d, cur_mode;
  logic        pres_q, pres_d, cur_pres, smp_pres;
  logic        rd, start;
  logic [7:0]  lo_cur, lo_eos;
  logic [TW-1:0] rel_cur_c, lo_eos_c;

  logic        out_valid_q;
  logic        drive_q, drive_d, busy_q, busy_d, done_q, done_d, nodev_q, nodev_d;
  logic [7:0]  rx_q, rx_d;

  assign q_pop_o = !q_empty_i && (!out_valid_q || !out_stall_i);
  assign start   = (phase_q == PH_IDLE) && item_i.cmd_ok;

  always_comb begin
    if (start) begin
      cur_mode  = item_i.mode;
      cur_shift = item_i.shift;
      cur_tick  = '0;
      cur_bit   = '0;
      cur_pres  = 1'b0;
    end else begin
      cur_mode  = mode_q;
      cur_shift = shift_q;
      cur_tick  = tick_q;
      cur_bit   = bit_q;
      cur_pres  = pres_q;
    end
    rd     = (cur_mode == MODE_RD_BIT) || (cur_mode == MODE_RD_BYTE);
    lo_cur = low_len(rd, cur_shift[0], cfg_i);

    if (!start) begin
      cur_ph = phase_q;
    end else if (item_i.is_reset) begin
      if (clamp_len(cfg_i.reset_low) != '0) begin
        cur_ph = PH_RLOW;
      end else if (clamp_len({2'd0, cfg_i.presence_wait}) != '0) begin
        cur_ph = PH_RWAIT;
      end else begin
        cur_ph = PH_RSAMP;
      end
    end else begin
      cur_ph = (clamp_len({2'd0, lo_cur}) != '0) ? PH_SLOW : PH_SREL;
    end

    smp_pres  = (cur_ph == PH_RSAMP) ? !item_i.bus : cur_pres;
    smp_shift = cur_shift;
    if (cur_ph == PH_SREL && rd && cur_tick == TW'(cfg_i.read_sample)) begin
      smp_shift = (cur_mode == MODE_RD_BYTE) ? {item_i.bus, cur_shift[7:1]}
                                             : {7'd0, item_i.bus};
    end

    rel_cur_c = clamp_len({2'd0, rel_len(rd, lo_cur, cfg_i)});

    unique case (cur_ph)
      PH_RLOW:  len = clamp_len(cfg_i.reset_low);
      PH_RWAIT: len = clamp_len({2'd0, cfg_i.presence_wait});
      PH_RSAMP: len = TW'(1);
      PH_RTAIL: len = clamp_len(cfg_i.reset_tail);
      PH_SLOW:  len = clamp_len({2'd0, lo_cur});
      PH_SREL:  len = rel_cur_c;
      default:  len = '0;
    endcase

    eos_bit   = cur_bit + 4'd1;
    eos_shift = (cur_mode == MODE_WR_BYTE) ? {1'b0, smp_shift[7:1]} : smp_shift;
    slots     = (cur_mode >= MODE_WR_BYTE) ? 4'd8 : 4'd1;
    lo_eos    = low_len(rd, eos_shift[0], cfg_i);
    lo_eos_c  = clamp_len({2'd0, lo_eos});
    if (eos_bit >= slots) begin
      eos_ph = PH_IDLE;
    end else begin
      eos_ph = (lo_eos_c != '0) ? PH_SLOW : PH_SREL;
    end

    tick_inc = {1'b0, cur_tick} + (TW+1)'(1);

    phase_d = cur_ph;
    tick_d  = tick_inc[TW-1:0];
    bit_d   = cur_bit;
    shift_d = smp_shift;
    mode_d  = cur_mode;
    pres_d  = smp_pres;

    if (cur_ph == PH_IDLE) begin
      tick_d  = cur_tick;
      shift_d = cur_shift;
      pres_d  = cur_pres;
    end else if (tick_inc >= {1'b0, len}) begin
      tick_d = '0;
      unique case (cur_ph)
        PH_RLOW: begin
          phase_d = (clamp_len({2'd0, cfg_i.presence_wait}) != '0) ? PH_RWAIT : PH_RSAMP;
        end
        PH_RWAIT: phase_d = PH_RSAMP;
        PH_RSAMP: begin
          phase_d = (clamp_len(cfg_i.reset_tail) != '0) ? PH_RTAIL : PH_IDLE;
        end
        PH_RTAIL: phase_d = PH_IDLE;
        PH_SLOW: begin
          if (rel_cur_c != '0) begin
            phase_d = PH_SREL;
          end else begin
            phase_d = eos_ph;
            bit_d   = eos_bit;
            shift_d = eos_shift;
          end
        end
        PH_SREL: begin
          phase_d = eos_ph;
          bit_d   = eos_bit;
          shift_d = eos_shift;
        end
        default: phase_d = PH_IDLE;
      endcase
    end

    drive_d = (cur_ph == PH_RLOW) || (cur_ph == PH_SLOW);
    busy_d  = (cur_ph != PH_IDLE);
    done_d  = busy_d && (phase_d == PH_IDLE);
    rx_d    = (done_d && rd) ? shift_d : 8'd0;
    nodev_d = done_d && (cur_mode == MODE_RESET) && !pres_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      tick_q      <= '0;
      bit_q       <= '0;
      shift_q     <= '0;
      mode_q      <= '0;
      pres_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (q_pop_o) begin
        phase_q <= phase_d;
        tick_q  <= tick_d;
        bit_q   <= bit_d;
        shift_q <= shift_d;
        mode_q  <= mode_d;
        pres_q  <= pres_d;
      end
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      drive_q <= drive_d;
      busy_q  <= busy_d;
      done_q  <= done_d;
      rx_q    <= rx_d;
      nodev_q <= nodev_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign drive_low_o = drive_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_data_o   = rx_q;
  assign no_device_o = nodev_q;

endmodule

// ===== rtl/onewire_master_slot_engine.sv =====
// ----------------------------------------------------------------------------
// 1-Wire bus master slot engine
// One request per microsecond tick; reset/presence, bit and byte slots.
//
//   channel  direction  handshake               payload
//   in       to block   in_valid_i/in_stall_o   cmd_valid, mode, tx_data, bus_level
//   out      from block out_valid_o/out_stall_i drive_low, busy_res, done_res,
//                                               rx_data, no_device
//   cfg      to block   cfg_we_i                cfg_index_i, cfg_wdata_i
//
// Sustained rate is one tick per clock while the output is not stalled; the
// phase timer and its length compare form the feedback loop in the slot sequencer.
// From accept to result a request passes a queue entry, then the output register.
// Reset puts the sequencer idle and loads standard-speed timing values.
// A two-entry queue lets input and output stall independently.
// ----------------------------------------------------------------------------
module onewire_master_slot_engine (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_valid_i,
  input  logic [2:0]                     mode_i,
  input  logic [7:0]                     tx_data_i,
  input  logic                           bus_level_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           drive_low_o,
  output logic                           busy_res_o,
  output logic                           done_res_o,
  output logic [7:0]                     rx_data_o,
  output logic                           no_device_o,
  input  logic                           cfg_we_i,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import owm_pkg::*;

  cfg_t  cfg;
  item_t push_item, head_item;
  logic  q_push, q_pop, q_full, q_empty;

  owm_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  owm_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_i (cmd_valid_i),
    .mode_i      (mode_i),
    .tx_data_i   (tx_data_i),
    .bus_level_i (bus_level_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_item_o    (push_item)
  );

  owm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (push_item),
    .pop_i   (q_pop),
    .item_o  (head_item),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  owm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .item_i      (head_item),
    .q_empty_i   (q_empty),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_low_o (drive_low_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_data_o   (rx_data_o),
    .no_device_o (no_device_o)
  );

endmodule

// ===== rtl/owm_checker.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master port checker
// Port-level checks on result consistency and output hold under stall.
// ----------------------------------------------------------------------------
`include "onewire_master_slot_engine_macros.svh"

module owm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       drive_low_o,
  input logic       busy_res_o,
  input logic       done_res_o,
  input logic [7:0] rx_data_o,
  input logic       no_device_o
);

  `OWM_ASSERT_IMP(a_drive_busy, out_valid_o && drive_low_o, busy_res_o,
                  "bus driven low outside a command")
  `OWM_ASSERT_IMP(a_idle_quiet, out_valid_o && !busy_res_o,
                  !done_res_o && !no_device_o && (rx_data_o == 8'd0),
                  "idle result carries status or data")
  `OWM_ASSERT_IMP(a_status_done, out_valid_o && (no_device_o || (rx_data_o != 8'd0)),
                  done_res_o, "status or data shown before command end")
  `OWM_ASSERT_NXT(a_hold, out_valid_o && out_stall_i,
                  out_valid_o && $stable(drive_low_o) && $stable(done_res_o)
                  && $stable(rx_data_o), "stalled result changed")

endmodule

bind onewire_master_slot_engine owm_checker u_owm_checker (.*);

// ===== bench/onewire_master_slot_engine_checker.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master slot engine checker
// Watches both channels and the register port. It keeps a tick-level model of
// the slot sequencer and queues the result each accepted request should
// produce. It then compares every delivered result, field by field, against
// the oldest queued one.
// ----------------------------------------------------------------------------
module onewire_master_slot_engine_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_o,
  input  logic                           cmd_valid_i,
  input  logic [2:0]                     mode_i,
  input  logic [7:0]                     tx_data_i,
  input  logic                           bus_level_i,
  input  logic                           out_valid_o,
  input  logic                           out_stall_i,
  input  logic                           drive_low_o,
  input  logic                           busy_res_o,
  input  logic                           done_res_o,
  input  logic [7:0]                     rx_data_o,
  input  logic                           no_device_o,
  input  logic                           cfg_we_i,
  input  logic [owm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [owm_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                             fail_count,
  output int                             pending,
  output logic                           seq_busy
);

  import owm_pkg::*;

  localparam int unsigned TICK_MAX = (1 << TIMER_WIDTH) - 1;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_RST_LOW,
    SEQ_RST_WAIT,
    SEQ_RST_SAMPLE,
    SEQ_RST_TAIL,
    SEQ_SLOT_LOW,
    SEQ_SLOT_REL
  } seq_phase_e;

  typedef struct packed {
    logic       drive;
    logic       busy;
    logic       done;
    logic [7:0] rx;
    logic       nodev;
  } tick_result_t;

  cfg_t          timing;
  seq_phase_e    seq_ph;
  int unsigned   tick_cnt;
  logic [3:0]    slot_cnt;
  logic [7:0]    shift_reg;
  logic [2:0]    cur_mode;
  logic          presence;
  tick_result_t  tick_results_q[$];

  function automatic logic is_read_mode();
    return (cur_mode == MODE_RD_BIT) || (cur_mode == MODE_RD_BYTE);
  endfunction

  function automatic int unsigned low_ticks();
    if (is_read_mode() || shift_reg[0]) return timing.short_low;
    return timing.write0_low;
  endfunction

  // skip every phase whose length is already used up
  function automatic void settle_seq();
    int unsigned len;
    int unsigned lo;
    int unsigned slots;
    logic        hold;
    hold = 1'b0;
    while (seq_ph != SEQ_IDLE && !hold) begin
      lo = low_ticks();
      case (seq_ph)
        SEQ_RST_LOW:    len = timing.reset_low;
        SEQ_RST_WAIT:   len = timing.presence_wait;
        SEQ_RST_SAMPLE: len = 1;
        SEQ_RST_TAIL:   len = timing.reset_tail;
        SEQ_SLOT_LOW:   len = lo;
        default: begin
          len = (timing.slot > lo) ? timing.slot - lo : 0;
          if (is_read_mode()) begin
            if (len < timing.read_sample + 1) len = timing.read_sample + 1;
          end else if (lo == 0 && len == 0) begin
            len = 1;
          end
        end
      endcase
      if (len > TICK_MAX) len = TICK_MAX;
      hold = (tick_cnt < len);
      if (!hold) begin
        slots = (cur_mode >= MODE_WR_BYTE) ? 8 : 1;
        case (seq_ph)
          SEQ_RST_LOW:    seq_ph = SEQ_RST_WAIT;
          SEQ_RST_WAIT:   seq_ph = SEQ_RST_SAMPLE;
          SEQ_RST_SAMPLE: seq_ph = SEQ_RST_TAIL;
          SEQ_SLOT_LOW:   seq_ph = SEQ_SLOT_REL;
          SEQ_SLOT_REL: begin
            slot_cnt = slot_cnt + 4'd1;
            if (cur_mode == MODE_WR_BYTE) shift_reg = shift_reg >> 1;
            seq_ph = (slot_cnt >= slots) ? SEQ_IDLE : SEQ_SLOT_LOW;
          end
          default:        seq_ph = SEQ_IDLE;
        endcase
        tick_cnt = 0;
      end
    end
  endfunction

  function automatic tick_result_t engine_tick(logic cmd, logic [2:0] md, logic [7:0] tx,
                                               logic bus);
    tick_result_t res;
    res = '0;
    if (seq_ph == SEQ_IDLE && cmd && md <= MODE_RD_BYTE) begin
      cur_mode = md;
      slot_cnt = '0;
      tick_cnt = 0;
      presence = 1'b0;
      if (md == MODE_RESET) begin
        seq_ph    = SEQ_RST_LOW;
        shift_reg = '0;
      end else begin
        seq_ph    = SEQ_SLOT_LOW;
        shift_reg = (md == MODE_WR_BIT) ? {7'd0, tx[0]} : (md == MODE_WR_BYTE) ? tx : 8'd0;
      end
      settle_seq();
    end
    if (seq_ph == SEQ_IDLE) return res;

    res.drive = (seq_ph == SEQ_RST_LOW) || (seq_ph == SEQ_SLOT_LOW);
    res.busy  = 1'b1;
    if (seq_ph == SEQ_RST_SAMPLE) presence = !bus;
    if (seq_ph == SEQ_SLOT_REL && is_read_mode() && tick_cnt == timing.read_sample) begin
      if (cur_mode == MODE_RD_BYTE) shift_reg = {bus, shift_reg[7:1]};
      else shift_reg = {7'd0, bus};
    end
    tick_cnt = tick_cnt + 1;
    settle_seq();
    res.done = (seq_ph == SEQ_IDLE);
    if (res.done) begin
      if (is_read_mode()) res.rx = shift_reg;
      if (cur_mode == MODE_RESET) res.nodev = !presence;
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      fail_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tick_result_t exp_r;
    if (!rst_ni) begin
      timing     = '{RESET_LOW_DEF, PRESENCE_WAIT_DEF, RESET_TAIL_DEF, SLOT_DEF,
                     SHORT_LOW_DEF, WRITE0_LOW_DEF, READ_SAMPLE_DEF};
      seq_ph     = SEQ_IDLE;
      tick_cnt   = 0;
      slot_cnt   = '0;
      shift_reg  = '0;
      cur_mode   = '0;
      presence   = 1'b0;
      fail_count = 0;
      tick_results_q.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (tick_results_q.size() == 0) begin
          fail_count++;
          $display("%0t: result with no pending request, actual drive=%0b busy=%0b done=%0b",
                   $time, drive_low_o, busy_res_o, done_res_o);
        end else begin
          exp_r = tick_results_q.pop_front();
          check_field("drive_low", 8'(exp_r.drive), 8'(drive_low_o));
          check_field("busy_res", 8'(exp_r.busy), 8'(busy_res_o));
          check_field("done_res", 8'(exp_r.done), 8'(done_res_o));
          check_field("rx_data", exp_r.rx, rx_data_o);
          check_field("no_device", 8'(exp_r.nodev), 8'(no_device_o));
        end
      end
      if (in_valid_i && !in_stall_o) begin
        tick_results_q.push_back(engine_tick(cmd_valid_i, mode_i, tx_data_i, bus_level_i));
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_RESET_LOW:     timing.reset_low     = cfg_wdata_i[9:0];
          REG_PRESENCE_WAIT: timing.presence_wait = cfg_wdata_i[7:0];
          REG_RESET_TAIL:    timing.reset_tail    = cfg_wdata_i[9:0];
          REG_SLOT:          timing.slot          = cfg_wdata_i[7:0];
          REG_SHORT_LOW:     timing.short_low     = cfg_wdata_i[5:0];
          REG_WRITE0_LOW:    timing.write0_low    = cfg_wdata_i[7:0];
          REG_READ_SAMPLE:   timing.read_sample   = cfg_wdata_i[5:0];
          default: ;
        endcase
      end
    end
    pending  = tick_results_q.size();
    seq_busy = (seq_ph != SEQ_IDLE);
  end

endmodule

// ===== bench/onewire_master_slot_engine_tb.sv =====
// ----------------------------------------------------------------------------
// 1-Wire master slot engine testbench
// Drives microsecond ticks carrying commands and bus levels into the slot
// engine under several timing settings and idle/stall mixes. A short directed
// pass covers every mode and the degenerate timings, then random commands
// follow. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module onewire_master_slot_engine_tb;

  import owm_pkg::*;

  localparam int QUIET_LIMIT    = 2000;
  localparam int ROUNDS         = 4;
  localparam int CMDS_PER_ROUND = 3;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  cmd_valid_i;
  logic [2:0]            mode_i;
  logic [7:0]            tx_data_i;
  logic                  bus_level_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic                  drive_low_o;
  logic                  busy_res_o;
  logic                  done_res_o;
  logic [7:0]            rx_data_o;
  logic                  no_device_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  int   fail_count;
  int   pending;
  logic seq_busy;
  int   idle_pct;
  int   stall_pct;
  int   quiet_cycles;

  onewire_master_slot_engine u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_i (cmd_valid_i),
    .mode_i      (mode_i),
    .tx_data_i   (tx_data_i),
    .bus_level_i (bus_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_low_o (drive_low_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_data_o   (rx_data_o),
    .no_device_o (no_device_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  onewire_master_slot_engine_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_i (cmd_valid_i),
    .mode_i      (mode_i),
    .tx_data_i   (tx_data_i),
    .bus_level_i (bus_level_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .drive_low_o (drive_low_o),
    .busy_res_o  (busy_res_o),
    .done_res_o  (done_res_o),
    .rx_data_o   (rx_data_o),
    .no_device_o (no_device_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fail_count  (fail_count),
    .pending     (pending),
    .seq_busy    (seq_busy)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_stall_i = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_tick(input logic cmd, input logic [2:0] md, input logic [7:0] tx,
                           input logic bus);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    cmd_valid_i = cmd;
    mode_i      = md;
    tx_data_i   = tx;
    bus_level_i = bus;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // issue one command, then feed ticks until the sequencer is idle again
  task automatic run_command(input logic [2:0] md, input logic [7:0] tx);
    logic noise;
    send_tick(1'b1, md, tx, 1'($urandom_range(0, 1)));
    while (seq_busy) begin
      noise = ($urandom_range(0, 5) == 0);
      send_tick(noise, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
    end
  endtask

  task automatic drain_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic load_timing(input int rl, input int pw, input int rt, input int sl,
                             input int sh, input int w0, input int rs);
    logic [CFG_IDX_W-1:0]  idx[7];
    int                    val[7];
    drain_results();
    idx = '{REG_RESET_LOW, REG_PRESENCE_WAIT, REG_RESET_TAIL, REG_SLOT,
            REG_SHORT_LOW, REG_WRITE0_LOW, REG_READ_SAMPLE};
    val = '{rl, pw, rt, sl, sh, w0, rs};
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    = 1'b1;
      cfg_index_i = idx[i];
      cfg_wdata_i = CFG_DATA_W'(val[i]);
      @(negedge clk_i);
    end
    cfg_we_i = 1'b0;
  endtask

  task automatic set_idling(input int sel);
    case (sel)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 46; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 46; end
      default: begin idle_pct = 24; stall_pct = 24; end
    endcase
  endtask

  initial begin
    logic [2:0] md;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    cmd_valid_i  = 1'b0;
    mode_i       = '0;
    tx_data_i    = '0;
    bus_level_i  = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_index_i  = '0;
    cfg_wdata_i  = '0;
    idle_pct     = 0;
    stall_pct    = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // standard timing after reset
    run_command(MODE_RD_BIT, 8'h00);
    run_command(3'd5, 8'h00);
    run_command(3'd6, 8'h55);
    run_command(3'd7, 8'hFF);

    // all zero timing: skipped phases and empty slots
    load_timing(0, 0, 0, 0, 0, 0, 0);
    run_command(MODE_RESET, 8'h00);
    run_command(MODE_WR_BIT, 8'h00);
    run_command(MODE_WR_BIT, 8'h01);
    run_command(MODE_RD_BIT, 8'h00);
    run_command(MODE_WR_BYTE, 8'h00);
    run_command(MODE_WR_BYTE, 8'hFF);
    run_command(MODE_RD_BYTE, 8'h00);

    // read sample past the end of the slot
    load_timing(3, 2, 3, 4, 2, 3, 5);
    run_command(MODE_RESET, 8'h00);
    run_command(MODE_RD_BIT, 8'h00);
    run_command(MODE_RD_BYTE, 8'h00);
    run_command(MODE_WR_BYTE, 8'h3C);

    for (int r = 0; r < ROUNDS; r++) begin
      load_timing($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 6),
                  $urandom_range(0, 8), $urandom_range(0, 4), $urandom_range(0, 8),
                  $urandom_range(0, 4));
      set_idling(r % 4);
      for (int c = 0; c < CMDS_PER_ROUND; c++) begin
        repeat ($urandom_range(0, 2)) begin
          send_tick(1'b0, 3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom_range(0, 1)));
        end
        md = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        run_command(md, 8'($urandom));
      end
    end

    drain_results();
    repeat (8) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
